FILE: sv/gmp_pkg.sv
// Shared types and constants for the grid max-path block.
// Used by the controller, the datapath, the top level and the checker.
package gmp_pkg;

  localparam int CELL_W  = 48;
  localparam int BEST_W  = 56;
  localparam int TOTAL_W = 64;
  localparam int VALUE_W = 32;
  localparam int COORD_W = 7;
  localparam int SIZE_W  = 7;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic upd_capture;
    logic cell_add;
    logic sweep_start;
    logic sweep_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_busy;
  } sts_t;

endpackage

FILE: sv/grid_max_path_dp_update.sv
// Grid max-path block: top level joining gmp_ctrl and gmp_dp.
// Depends on gmp_pkg, gmp_ram, gmp_ctrl and gmp_dp.
//
// Input channel (in_valid/in_ready): in_func selects a load (write one cell,
// no result) or an update (add in_value to one cell, saturating to 48 bits,
// then rebuild the best-path table and send one result).
// Result channel (out_valid/out_ready): out_grid_total is the 64-bit wrapping
// sum of the best path values over the grid in use.
// cfg_we/cfg_wdata writes grid_size; write it only while the block is idle.
// Loads may follow back to back.
// An update sweeps every cell of the side*side grid in row-major order, one
// cell per cycle through the cell and path memories; after the sweep the
// controller passes through its drain and done states, loads the result in
// the done state and takes the next item once it is back in the idle state.
// The result sits in an output register; loads are taken while it waits.
// A second update finishes its sweep and then holds until that register
// is free.
// Reset clears control state and sets grid_size to 64; cell contents are
// undefined until loaded.
module grid_max_path_dp_update #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gmp_pkg::SIZE_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [gmp_pkg::COORD_W-1:0]         in_row,
  input  logic [gmp_pkg::COORD_W-1:0]         in_col,
  input  logic signed [gmp_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gmp_pkg::TOTAL_W-1:0]  out_grid_total
);

  gmp_pkg::cmd_t cmd;
  gmp_pkg::sts_t sts;

  gmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  gmp_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_grid_total (out_grid_total),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

FILE: sv/gmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gmp_ctrl.sv
// Controller state machine for the grid max-path block.
// Depends on gmp_pkg; drives the datapath through cmd_t, watches sts_t.
module gmp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  output gmp_pkg::cmd_t cmd,
  input  gmp_pkg::sts_t sts
);

  gmp_pkg::state_t state_r;
  gmp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gmp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == gmp_pkg::FUNC_UPDATE) begin
            cmd.upd_capture = 1'b1;
            state_nxt       = gmp_pkg::ST_ADD;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      gmp_pkg::ST_ADD: begin
        cmd.cell_add    = 1'b1;
        cmd.sweep_start = 1'b1;
        state_nxt       = gmp_pkg::ST_SWEEP;
      end
      gmp_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = gmp_pkg::ST_DRAIN;
        end
      end
      gmp_pkg::ST_DRAIN: begin
        state_nxt = gmp_pkg::ST_DONE;
      end
      gmp_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = gmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gmp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/gmp_dp.sv
// Datapath: cell and best-path memories, sweep counters, path adder, total.
// Depends on gmp_pkg and gmp_ram; commanded by gmp_ctrl.
module gmp_dp #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gmp_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic [gmp_pkg::COORD_W-1:0]          in_row,
  input  logic [gmp_pkg::COORD_W-1:0]          in_col,
  input  logic signed [gmp_pkg::VALUE_W-1:0]   in_value,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [gmp_pkg::TOTAL_W-1:0]   out_grid_total,
  input  gmp_pkg::cmd_t                        cmd,
  output gmp_pkg::sts_t                        sts
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_SIDE);
  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int CELL_W = gmp_pkg::CELL_W;
  localparam int BEST_W = gmp_pkg::BEST_W;
  localparam int TOT_W  = gmp_pkg::TOTAL_W;
  localparam int VAL_W  = gmp_pkg::VALUE_W;

  logic [gmp_pkg::SIZE_W-1:0] grid_size_r;
  logic [SW-1:0]              side;
  logic [CW-1:0]              side_m1;
  logic                       in_inside;
  logic [ADDR_W-1:0]          in_idx;

  logic [ADDR_W-1:0]          upd_idx_r;
  logic                       upd_inside_r;
  logic signed [VAL_W-1:0]    upd_value_r;

  logic                       cell_we;
  logic [ADDR_W-1:0]          cell_waddr;
  logic [CELL_W-1:0]          cell_wdata;
  logic [ADDR_W-1:0]          cell_raddr;
  logic [CELL_W-1:0]          cell_rdata;
  logic signed [CELL_W:0]     add_sum;
  logic [CELL_W-1:0]          add_sat;

  logic [CW-1:0]              r_r;
  logic [CW-1:0]              c_r;
  logic [ADDR_W-1:0]          k_r;
  logic                       s1_valid_r;
  logic [ADDR_W-1:0]          s1_k_r;
  logic                       s1_top_r;
  logic                       s1_lft_r;

  logic [ADDR_W-1:0]          best_raddr;
  logic [BEST_W-1:0]          best_rdata;
  logic signed [BEST_W-1:0]   cell_ext;
  logic signed [BEST_W-1:0]   pred;
  logic signed [BEST_W-1:0]   nv;
  logic signed [BEST_W-1:0]   left_r;
  logic [TOT_W-1:0]           total_r;

  logic                       out_valid_r;
  logic [TOT_W-1:0]           out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= gmp_pkg::GRID_SIZE_RESET;
    end else if (cfg_we) begin
      grid_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (grid_size_r == '0) begin
      side = SW'(1);
    end else if (int'(grid_size_r) > MAX_SIDE) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_size_r);
    end
    side_m1 = CW'(side - SW'(1));
  end

  always_comb begin
    int lin;
    lin       = (int'(in_row) - 1) * MAX_SIDE + int'(in_col) - 1;
    in_inside = (in_row != '0) && (in_col != '0) &&
                (int'(in_row) <= int'(side)) && (int'(in_col) <= int'(side));
    in_idx    = in_inside ? ADDR_W'(lin) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_capture) begin
      upd_idx_r    <= in_idx;
      upd_inside_r <= in_inside;
      upd_value_r  <= in_value;
    end
  end

  always_comb begin
    add_sum = $signed({cell_rdata[CELL_W-1], cell_rdata}) +
              $signed({{(CELL_W + 1 - VAL_W){upd_value_r[VAL_W-1]}}, upd_value_r});
    if (add_sum[CELL_W] != add_sum[CELL_W-1]) begin
      add_sat = add_sum[CELL_W] ? {1'b1, {(CELL_W - 1){1'b0}}}
                                : {1'b0, {(CELL_W - 1){1'b1}}};
    end else begin
      add_sat = add_sum[CELL_W-1:0];
    end
  end

  always_comb begin
    cell_we    = (cmd.load_wr && in_inside) || (cmd.cell_add && upd_inside_r);
    cell_waddr = cmd.cell_add ? upd_idx_r : in_idx;
    cell_wdata = cmd.cell_add ? add_sat
                              : {{(CELL_W - VAL_W){in_value[VAL_W-1]}}, in_value};
    cell_raddr = cmd.sweep_step ? k_r : in_idx;
  end

  gmp_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      r_r <= '0;
      c_r <= '0;
      k_r <= '0;
    end else if (cmd.sweep_step) begin
      if (c_r == side_m1) begin
        c_r <= '0;
        r_r <= r_r + CW'(1);
        k_r <= k_r + ADDR_W'(MAX_SIDE) - ADDR_W'(side_m1);
      end else begin
        c_r <= c_r + CW'(1);
        k_r <= k_r + ADDR_W'(1);
      end
    end
  end

  assign sts.sweep_last = (r_r == side_m1) && (c_r == side_m1);
  assign sts.out_busy   = out_valid_r && !out_ready;
  assign best_raddr     = k_r - ADDR_W'(MAX_SIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r   <= k_r;
    s1_top_r <= (r_r == '0);
    s1_lft_r <= (c_r == '0);
  end

  gmp_ram #(.WIDTH(BEST_W), .DEPTH(DEPTH)) u_best_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_k_r),
    .wdata (nv),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  always_comb begin
    cell_ext = $signed({{(BEST_W - CELL_W){cell_rdata[CELL_W-1]}}, cell_rdata});
    if (s1_top_r && s1_lft_r) begin
      pred = '0;
    end else if (s1_top_r) begin
      pred = left_r;
    end else if (s1_lft_r) begin
      pred = $signed(best_rdata);
    end else if ($signed(best_rdata) > left_r) begin
      pred = $signed(best_rdata);
    end else begin
      pred = left_r;
    end
    nv = cell_ext + pred;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      left_r <= nv;
    end
    if (cmd.sweep_start) begin
      total_r <= '0;
    end else if (s1_valid_r) begin
      total_r <= total_r + {{(TOT_W - BEST_W){nv[BEST_W-1]}}, nv};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total_r <= total_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_grid_total = $signed(out_total_r);

endmodule

FILE: sv/gmp_chk.sv
// Port-level checker for grid_max_path_dp_update, attached by bind.
// Depends on gmp_pkg.
module gmp_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_func,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [gmp_pkg::TOTAL_W-1:0] out_grid_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_grid_total))
    else $error("result dropped or changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == gmp_pkg::FUNC_LOAD) && !out_valid
    |=> !out_valid)
    else $error("load produced a result");

  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == gmp_pkg::FUNC_UPDATE) |=> !in_ready)
    else $error("input taken during update sweep");

  a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished update");

endmodule

bind grid_max_path_dp_update gmp_chk u_gmp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_grid_total (out_grid_total)
);
